/* rtl/core/hta_pkg.sv */
package hta_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_GET     = 3'd1,
        OP_GET_RET = 3'd2,
        OP_CLOSE   = 3'd3,
        OP_CLEAR   = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_INVALID_VALUE  = 2'd1,
        ST_INVALID_HANDLE = 2'd2,
        ST_TABLE_FULL     = 2'd3
    } status_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] lookup_id;
        logic [7:0]  obj_type;
        logic [63:0] object_ref;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_id;
        logic [7:0]  result_type;
        logic [63:0] result_ref;
        logic        retain_flag;
        logic        release_flag;
        logic        last;
    } res_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PROBE,
        BK_SHIFT,
        BK_CLEAR,
        BK_OUT
    } bk_state_t;

endpackage

/* rtl/core/hta_front.sv */
module hta_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hta_pkg::cmd_t in_cmd,
    output logic          q_valid,
    input  logic          q_ready,
    output hta_pkg::cmd_t q_cmd
);
    import hta_pkg::*;

    // two-entry queue between front and back
    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    logic push, pop;
    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push)
        else $error("push into full queue");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not advance");

endmodule

/* rtl/core/hta_back.sv */
module hta_back
#(
    parameter int TABLE_DEPTH = hta_pkg::TABLE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    counted_type,
    input  logic          q_valid,
    output logic          q_ready,
    input  hta_pkg::cmd_t q_cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output hta_pkg::res_t res
);
    import hta_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // entry cells, read at fixed places or through the compare array
    logic [31:0] id_reg   [TABLE_DEPTH];
    logic [7:0]  type_reg [TABLE_DEPTH];
    logic [63:0] ref_reg  [TABLE_DEPTH];
    logic [CW-1:0] count_reg;
    logic [31:0]   hint_reg;

    bk_state_t   state_reg, state_next;
    cmd_t        cmd_reg;
    logic [31:0] probe_reg;
    logic [IW-1:0] pos_reg;
    res_t        res_reg;

    // compare every live cell against one key
    logic [31:0]   key;
    logic          hit;
    logic [IW-1:0] hit_idx;
    always_comb
    begin
        key     = (state_reg == BK_PROBE) ? probe_reg : q_cmd.lookup_id;
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if ((CW'(i) < count_reg) && id_reg[i] == key)
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    logic        take;
    logic        out_busy;
    assign out_busy  = res_valid && !res_ready;
    assign q_ready   = (state_reg == BK_IDLE) && !out_busy;
    assign take      = q_valid && q_ready;
    assign res_valid = (state_reg == BK_OUT);
    assign res       = res_reg;

    logic last_clear;
    assign last_clear = (CW'(pos_reg) + CW'(1) >= count_reg);

    // result loaded when a command is taken
    res_t take_res;
    always_comb
    begin
        take_res      = '0;
        take_res.last = 1'b1;
        case (q_cmd.opcode)
            OP_CREATE:
            begin
                if (q_cmd.object_ref == 64'd0)
                    take_res.status = ST_INVALID_VALUE;
                else if (count_reg >= CW'(TABLE_DEPTH))
                    take_res.status = ST_TABLE_FULL;
            end
            OP_GET, OP_GET_RET, OP_CLOSE:
            begin
                if (!hit)
                    take_res.status = ST_INVALID_HANDLE;
                else
                begin
                    take_res.result_id   = q_cmd.lookup_id;
                    take_res.result_type = type_reg[hit_idx];
                    take_res.result_ref  = ref_reg[hit_idx];
                    take_res.retain_flag = (q_cmd.opcode == OP_GET_RET) &&
                        type_reg[hit_idx] == counted_type;
                    take_res.release_flag = (q_cmd.opcode == OP_CLOSE) &&
                        type_reg[hit_idx] == counted_type;
                end
            end
            OP_CLEAR: ;
            default:  take_res.status = ST_INVALID_VALUE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (take)
                begin
                    case (q_cmd.opcode)
                        OP_CREATE:
                            state_next = (q_cmd.object_ref == 64'd0 ||
                                count_reg >= CW'(TABLE_DEPTH)) ? BK_OUT : BK_PROBE;
                        OP_CLOSE:  state_next = hit ? BK_SHIFT : BK_OUT;
                        OP_CLEAR:  state_next = (count_reg == '0) ? BK_OUT : BK_CLEAR;
                        default:   state_next = BK_OUT;
                    endcase
                end
            end
            BK_PROBE: if (!hit) state_next = BK_OUT;
            BK_SHIFT: if (CW'(pos_reg) + CW'(1) >= count_reg) state_next = BK_OUT;
            BK_CLEAR: state_next = BK_OUT;
            BK_OUT:
            begin
                if (res_ready)
                    state_next = (cmd_reg.opcode == OP_CLEAR && !res_reg.last)
                        ? BK_CLEAR : BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
            hint_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_PROBE && !hit)
            begin
                count_reg <= count_reg + CW'(1);
                hint_reg  <= probe_reg + 32'd1;
            end
            if (state_reg == BK_SHIFT && CW'(pos_reg) + CW'(1) >= count_reg)
                count_reg <= count_reg - CW'(1);
            if (take && q_cmd.opcode == OP_CLEAR)
                hint_reg <= '0;
            if (state_reg == BK_OUT && res_ready && cmd_reg.opcode == OP_CLEAR &&
                res_reg.last)
                count_reg <= '0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg   <= q_cmd;
            probe_reg <= hint_reg;
            pos_reg   <= (q_cmd.opcode == OP_CLEAR) ? '0 : hit_idx;
            res_reg   <= take_res;
        end
        else
        begin
            case (state_reg)
                BK_PROBE:
                begin
                    if (hit)
                        probe_reg <= probe_reg + 32'd1;
                    else
                    begin
                        id_reg[count_reg[IW-1:0]]   <= probe_reg;
                        type_reg[count_reg[IW-1:0]] <= cmd_reg.obj_type;
                        ref_reg[count_reg[IW-1:0]]  <= cmd_reg.object_ref;
                        res_reg.result_id   <= probe_reg;
                        res_reg.result_type <= cmd_reg.obj_type;
                        res_reg.result_ref  <= cmd_reg.object_ref;
                        res_reg.retain_flag <= cmd_reg.obj_type == counted_type;
                    end
                end
                BK_SHIFT:
                begin
                    if (CW'(pos_reg) + CW'(1) < count_reg)
                    begin
                        id_reg[pos_reg]   <= id_reg[pos_reg + IW'(1)];
                        type_reg[pos_reg] <= type_reg[pos_reg + IW'(1)];
                        ref_reg[pos_reg]  <= ref_reg[pos_reg + IW'(1)];
                        pos_reg <= pos_reg + IW'(1);
                    end
                end
                BK_CLEAR:
                begin
                    res_reg.status       <= ST_OK;
                    res_reg.result_id    <= id_reg[pos_reg];
                    res_reg.result_type  <= type_reg[pos_reg];
                    res_reg.result_ref   <= ref_reg[pos_reg];
                    res_reg.retain_flag  <= 1'b0;
                    res_reg.release_flag <= type_reg[pos_reg] == counted_type;
                    res_reg.last         <= last_clear;
                end
                BK_OUT:
                begin
                    if (res_ready && cmd_reg.opcode == OP_CLEAR && !res_reg.last)
                        pos_reg <= pos_reg + IW'(1);
                end
                default: ;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above depth");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> state_reg == BK_IDLE)
        else $error("command taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_reg))
        else $error("result changed under stall");

endmodule

/* rtl/core/handle_table_allocator_top.sv */
// Handle table allocator.
// Input words arrive on s_axis (tvalid/tready/tdata); results leave on
// m_axis with tlast marking the final result of one input word.
// counted_type is written through cfg_we/cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce.
// Input words pass a two-entry queue into the executing back end, so the
// front keeps accepting while a result waits on m_axis.
// Get, get_retained and errors load the result directly; create probes ids
// upward from the hint, up to TABLE_DEPTH of them; close shifts the entries
// behind the removed one down; clear emits one result per live entry.
// Rate is set by the single back-end sequencer: one word at a time.
// Reset empties the table, zeroes the id counter and counted_type.
// When m_axis stalls, the result is held and the back end waits; the
// queue fills and then s_axis_tready drops.
module handle_table_allocator_top
#(
    parameter int TABLE_DEPTH = hta_pkg::TABLE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[2:0], lookup_id[34:3], obj_type[42:35], object_ref[106:43], zero
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], result_id[33:2], result_type[41:34], result_ref[105:42],
    // retain_flag[106], release_flag[107], zero
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import hta_pkg::*;

    logic [7:0] counted_type_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            counted_type_reg <= 8'd0;
        else if (cfg_we)
            counted_type_reg <= cfg_data;
    end

    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;
    res_t res;

    assign in_cmd.opcode     = s_axis_tdata[2:0];
    assign in_cmd.lookup_id  = s_axis_tdata[34:3];
    assign in_cmd.obj_type   = s_axis_tdata[42:35];
    assign in_cmd.object_ref = s_axis_tdata[106:43];

    hta_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    hta_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .counted_type (counted_type_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd),
        .res_valid    (m_axis_tvalid),
        .res_ready    (m_axis_tready),
        .res          (res)
    );

    assign m_axis_tdata = {4'd0, res.release_flag, res.retain_flag, res.result_ref,
                           res.result_type, res.result_id, res.status};
    assign m_axis_tlast = res.last;

endmodule

/* tb/sv/handle_table_checker.sv */
module handle_table_checker
#(
    parameter int DEPTH = hta_pkg::TABLE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [111:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending
);
    import hta_pkg::*;

    // predicted table contents, in creation order
    logic [31:0] tbl_id [DEPTH];
    logic [7:0]  tbl_type [DEPTH];
    logic [63:0] tbl_ref [DEPTH];
    int          tbl_count;
    logic [31:0] id_hint;
    logic [7:0]  counted;
    res_t        result_q [$];

    function automatic int find_slot(logic [31:0] id);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic res_t mk(status_t st, logic [31:0] id, logic [7:0] ty,
                                logic [63:0] rf, logic ret, logic rel, logic lst);
        res_t r;
        r.status = st;
        r.result_id = id;
        r.result_type = ty;
        r.result_ref = rf;
        r.retain_flag = ret;
        r.release_flag = rel;
        r.last = lst;
        return r;
    endfunction

    // apply one command to the table and queue the results it causes
    task automatic apply_cmd(logic [111:0] w);
        logic [2:0]  op;
        logic [31:0] hid;
        logic [7:0]  ty;
        logic [63:0] rf;
        logic [31:0] id;
        int          k;
        op = w[2:0];
        hid = w[34:3];
        ty = w[42:35];
        rf = w[106:43];
        case (op)
            OP_CREATE:
            begin
                if (rf == 0)
                    result_q.push_back(mk(ST_INVALID_VALUE, 0, 0, 0, 0, 0, 1));
                else if (tbl_count >= DEPTH)
                    result_q.push_back(mk(ST_TABLE_FULL, 0, 0, 0, 0, 0, 1));
                else
                begin
                    id = id_hint;
                    while (find_slot(id) >= 0)
                        id = id + 1;
                    tbl_id[tbl_count] = id;
                    tbl_type[tbl_count] = ty;
                    tbl_ref[tbl_count] = rf;
                    tbl_count++;
                    id_hint = id + 1;
                    result_q.push_back(mk(ST_OK, id, ty, rf, ty == counted, 0, 1));
                end
            end
            OP_GET, OP_GET_RET:
            begin
                k = find_slot(hid);
                if (k < 0)
                    result_q.push_back(mk(ST_INVALID_HANDLE, 0, 0, 0, 0, 0, 1));
                else
                    result_q.push_back(mk(ST_OK, hid, tbl_type[k], tbl_ref[k],
                        op == OP_GET_RET && tbl_type[k] == counted, 0, 1));
            end
            OP_CLOSE:
            begin
                k = find_slot(hid);
                if (k < 0)
                    result_q.push_back(mk(ST_INVALID_HANDLE, 0, 0, 0, 0, 0, 1));
                else
                begin
                    result_q.push_back(mk(ST_OK, hid, tbl_type[k], tbl_ref[k], 0,
                        tbl_type[k] == counted, 1));
                    for (int i = k; i + 1 < tbl_count; i++)
                    begin
                        tbl_id[i] = tbl_id[i + 1];
                        tbl_type[i] = tbl_type[i + 1];
                        tbl_ref[i] = tbl_ref[i + 1];
                    end
                    tbl_count--;
                end
            end
            OP_CLEAR:
            begin
                if (tbl_count == 0)
                    result_q.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
                for (int i = 0; i < tbl_count; i++)
                    result_q.push_back(mk(ST_OK, tbl_id[i], tbl_type[i], tbl_ref[i], 0,
                        tbl_type[i] == counted, i + 1 == tbl_count));
                tbl_count = 0;
                id_hint = 0;
            end
            default:
                result_q.push_back(mk(ST_INVALID_VALUE, 0, 0, 0, 0, 0, 1));
        endcase
    endtask

    // compare one returned word against the oldest prediction
    task automatic check_word(logic [111:0] d, logic lst);
        res_t got;
        res_t want;
        got = mk(status_t'(d[1:0]), d[33:2], d[41:34], d[105:42], d[106], d[107], lst);
        if (result_q.size() == 0)
        begin
            $display("%0t: unexpected result %h", $realtime, got);
            fail_count++;
        end
        else
        begin
            want = result_q.pop_front();
            if (got !== want || d[111:108] !== 4'd0)
            begin
                $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_count = 0;
            id_hint = 0;
            counted = 0;
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_word(m_axis_tdata, m_axis_tlast);
            if (cfg_we)
                counted = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                apply_cmd(s_axis_tdata);
            pending = result_q.size();
        end
    end

endmodule

/* tb/sv/tb_handle_table_allocator_top.sv */
module tb_handle_table_allocator_top;
    import hta_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [7:0]   cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;
    int           fail_count;
    int           pending;
    int           cycle_cnt = 0;
    logic [31:0]  known_ids [$];

    localparam int CYCLE_LIMIT = 400000;

    handle_table_allocator_top u_top (.*);

    handle_table_checker #(.DEPTH(TABLE_DEPTH_DEF)) u_chk (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // cycle watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // sink side: random stalls, short mostly, some long, some none
    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) < 40)
            m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 9) == 0)
            m_axis_tready <= ($urandom_range(0, 30) == 0);
        else
            m_axis_tready <= $urandom_range(0, 1);
    end

    // idle cycles between words; tvalid stays up when there is no gap
    task automatic gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0)
            n = 0;
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // send one command word and wait for acceptance
    task automatic send(logic [2:0] op, logic [31:0] hid, logic [7:0] ty, logic [63:0] rf);
        s_axis_tdata <= {5'd0, rf, ty, hid, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        gap();
    endtask

    function automatic logic [63:0] rand_ref();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [31:0] pick_id();
        if (known_ids.size() > 0 && $urandom_range(0, 3) != 0)
            return known_ids[$urandom_range(0, known_ids.size() - 1)]
                + ($urandom_range(0, 5) == 0);
        return $urandom_range(0, 40);
    endfunction

    // wait until results drain, then for the block to settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_counted(logic [7:0] v);
        drain();
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic rand_phase(int n, logic [7:0] ty_hi);
        logic [2:0] op;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            op = r < 40 ? OP_CREATE : r < 55 ? OP_GET : r < 68 ? OP_GET_RET
                : r < 88 ? OP_CLOSE : r < 95 ? OP_CLEAR : 3'($urandom_range(5, 7));
            send(op, pick_id(), 8'($urandom_range(0, ty_hi)),
                 ($urandom_range(0, 15) == 0) ? 64'd0 : rand_ref());
            if (op == OP_CLEAR)
                known_ids.delete();
            else if (op == OP_CREATE)
                known_ids.push_back(u_chk_last_id());
        end
    endtask

    // ids are assigned from the hint; cover them by guessing a small range
    function automatic logic [31:0] u_chk_last_id();
        return $urandom_range(0, 40);
    endfunction

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_data = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: errors, empty clear, fill to full, lookups, close, clear
        send(OP_CLEAR, 0, 0, 0);
        send(OP_CREATE, 0, 8'd0, 64'd0);
        send(3'd5, 32'hFFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send(3'd7, 0, 0, 1);
        send(OP_GET, 32'hFFFF_FFFF, 0, 0);
        for (int i = 0; i < 17; i++)
            send(OP_CREATE, 0, (i % 2) ? 8'hFF : 8'h00,
                 (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd1 + i);
        send(OP_GET, 3, 0, 0);
        send(OP_GET_RET, 0, 0, 0);
        send(OP_CLOSE, 5, 0, 0);
        send(OP_CLOSE, 5, 0, 0);
        send(OP_CREATE, 0, 8'h00, 64'h8000_0000_0000_0000);
        send(OP_CLEAR, 0, 0, 0);

        set_counted(8'hFF);
        rand_phase(60, 8'hFF);
        set_counted(8'd3);
        rand_phase(60, 8'd7);
        set_counted(8'd0);
        rand_phase(55, 8'd3);

        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
